>>> rtl/oif_pkg.sv
// shared constants and types for the obstacle inflation fill block
package oif_pkg;

    localparam int MAX_ROWS    = 128;
    localparam int MAX_COLS    = 128;
    localparam int QUEUE_DEPTH = 131072;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int PIX_W  = ROW_W + COL_W;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;
    localparam int RAD_W  = 15;
    localparam int AREA_W = 8;
    localparam int CFG_W  = 15;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_ROWS   = 2'd1;
    localparam logic [1:0] CFG_COLS   = 2'd2;

    typedef struct packed {
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        logic [ROW_W-1:0] sr;
        logic [COL_W-1:0] sc;
    } qentry_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } qctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

endpackage

>>> rtl/obstacle_inflation_fill.sv
// obstacle inflation by breadth-first brushfire over a seed bitmap
//
//  channel   | signals                              | handshake
//  ----------+--------------------------------------+---------------------------
//  command   | command, row, col, seed              | start high while busy low
//  result    | inflated, boundary, overflow         | done high for one cycle
//  config    | cfg_index, cfg_data                  | cfg_write high
//
// write seed and unused commands answer in the cycle after the transaction,
// read answers by way of the S_READ state (registered bitmap read)
// run: a clear of the result maps, a raster scan of the area in states S_SCAN_RD
// and S_SCAN_CHK, then per queue entry S_POP, S_LOOK, S_CHECK and as needed S_MUL2,
// S_CMP and S_PUSH, paced by the shared squarer and the single queue write port
// after reset a clearing pass runs over all three maps with busy high
// results cannot be held off; each is shown for exactly one cycle
module obstacle_inflation_fill
    import oif_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic [ROW_W-1:0]  row,
    input  logic [COL_W-1:0]  col,
    input  logic              seed,
    output logic              done,
    output logic              inflated,
    output logic              boundary,
    output logic              overflow,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLEAR    = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CHK = 4'd3;
    localparam logic [3:0] S_POP      = 4'd4;
    localparam logic [3:0] S_LOOK     = 4'd5;
    localparam logic [3:0] S_CHECK    = 4'd6;
    localparam logic [3:0] S_MUL2     = 4'd7;
    localparam logic [3:0] S_CMP      = 4'd8;
    localparam logic [3:0] S_PUSH     = 4'd9;
    localparam logic [3:0] S_READ     = 4'd10;

    logic [3:0] state_reg, state_next;

    // configuration
    logic [RAD_W-1:0]  radius_reg;
    logic [AREA_W-1:0] rows_reg, cols_reg;
    logic [AREA_W-1:0] area_val, area_rows, area_cols;

    // bitmaps
    logic seed_mem [MAX_ROWS*MAX_COLS];
    logic infl_mem [MAX_ROWS*MAX_COLS];
    logic bnd_mem  [MAX_ROWS*MAX_COLS];
    logic seed_q, infl_q, bnd_q;
    logic [PIX_W-1:0] seed_wa, seed_ra, map_wa, map_ra;
    logic seed_we, seed_wd, infl_we, infl_wd, bnd_we, bnd_wd;

    // sequencer registers
    logic [PIX_W-1:0] clr_reg, clr_next;
    logic             clr_seed_reg, clr_seed_next;
    logic [ROW_W-1:0] scan_r_reg, scan_r_next;
    logic [COL_W-1:0] scan_c_reg, scan_c_next;
    qentry_t          ent_reg, ent_next;
    logic [RAD_W-1:0] acc_reg, acc_next;
    logic [1:0]       nb_reg, nb_next;
    logic             ovf_reg, ovf_next;
    logic             done_reg, done_next;
    logic             infl_out_reg, infl_out_next;
    logic             bnd_out_reg, bnd_out_next;

    // shared squarer
    logic [ROW_W-1:0]   dx, dy, mul_op;
    logic [2*ROW_W-1:0] prod;

    // queue
    qctl_t   qctl;
    qentry_t q_push_data, q_pop_data;
    qstat_t  qstat;

    logic accept;

    oif_fill_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (qctl),
        .push_data (q_push_data),
        .pop_data  (q_pop_data),
        .stat      (qstat)
    );

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign done     = done_reg;
    assign inflated = infl_out_reg;
    assign boundary = bnd_out_reg;
    assign overflow = ovf_reg;

    // area registers: zero acts as one, above the map acts as the map size
    assign area_val  = cfg_data[AREA_W-1:0];
    assign area_rows = (area_val == '0) ? AREA_W'(1) :
                       (area_val > AREA_W'(MAX_ROWS)) ? AREA_W'(MAX_ROWS) : area_val;
    assign area_cols = (area_val == '0) ? AREA_W'(1) :
                       (area_val > AREA_W'(MAX_COLS)) ? AREA_W'(MAX_COLS) : area_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RAD_W'(100);
            rows_reg   <= AREA_W'(MAX_ROWS);
            cols_reg   <= AREA_W'(MAX_COLS);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_data[RAD_W-1:0];
                CFG_ROWS:   rows_reg   <= area_rows;
                CFG_COLS:   cols_reg   <= area_cols;
                default:    ;
            endcase
        end
    end

    // distance of the current entry to its source, one axis per cycle
    assign dx     = (ent_reg.r >= ent_reg.sr) ? ent_reg.r - ent_reg.sr : ent_reg.sr - ent_reg.r;
    assign dy     = (ent_reg.c >= ent_reg.sc) ? ent_reg.c - ent_reg.sc : ent_reg.sc - ent_reg.c;
    assign mul_op = (state_reg == S_CHECK) ? dx : dy;
    assign prod   = mul_op * mul_op;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        clr_seed_next = clr_seed_reg;
        scan_r_next   = scan_r_reg;
        scan_c_next   = scan_c_reg;
        ent_next      = ent_reg;
        acc_next      = acc_reg;
        nb_next       = nb_reg;
        ovf_next      = ovf_reg;
        done_next     = 1'b0;
        infl_out_next = 1'b0;
        bnd_out_next  = 1'b0;

        qctl        = '0;
        q_push_data = ent_reg;

        seed_we = 1'b0;
        seed_wd = 1'b0;
        seed_wa = {row, col};
        seed_ra = {scan_r_reg, scan_c_reg};
        infl_we = 1'b0;
        infl_wd = 1'b0;
        bnd_we  = 1'b0;
        bnd_wd  = 1'b0;
        map_wa  = {ent_reg.r, ent_reg.c};
        map_ra  = {row, col};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        CMD_WRITE:
                        begin
                            seed_we   = 1'b1;
                            seed_wd   = seed;
                            done_next = 1'b1;
                        end
                        CMD_RUN:
                        begin
                            qctl.clear    = 1'b1;
                            ovf_next      = 1'b0;
                            clr_next      = '0;
                            clr_seed_next = 1'b0;
                            state_next    = S_CLEAR;
                        end
                        CMD_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                done_next     = 1'b1;
                infl_out_next = infl_q;
                bnd_out_next  = bnd_q;
                state_next    = S_IDLE;
            end
            S_CLEAR:
            begin
                map_wa  = clr_reg;
                seed_wa = clr_reg;
                infl_we = 1'b1;
                bnd_we  = 1'b1;
                seed_we = clr_seed_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    clr_seed_next = 1'b0;
                    scan_r_next   = '0;
                    scan_c_next   = '0;
                    state_next    = clr_seed_reg ? S_IDLE : S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                // every seed becomes its own source
                q_push_data = '{r: scan_r_reg, c: scan_c_reg, sr: scan_r_reg, sc: scan_c_reg};
                if (seed_q)
                begin
                    qctl.push = 1'b1;
                    if (qstat.full)
                        ovf_next = 1'b1;
                end
                state_next = S_SCAN_RD;
                if ({1'b0, scan_c_reg} + 1'b1 < cols_reg)
                    scan_c_next = scan_c_reg + 1'b1;
                else
                begin
                    scan_c_next = '0;
                    if ({1'b0, scan_r_reg} + 1'b1 < rows_reg)
                        scan_r_next = scan_r_reg + 1'b1;
                    else
                        state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (qstat.empty)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    qctl.pop   = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                ent_next   = q_pop_data;
                map_ra     = {q_pop_data.r, q_pop_data.c};
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (infl_q)
                    state_next = S_POP;
                else
                begin
                    acc_next   = RAD_W'(prod);
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                acc_next   = acc_reg + RAD_W'(prod);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (acc_reg > radius_reg)
                begin
                    bnd_we     = 1'b1;
                    bnd_wd     = 1'b1;
                    state_next = S_POP;
                end
                else
                begin
                    infl_we    = 1'b1;
                    infl_wd    = 1'b1;
                    nb_next    = '0;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                // neighbour order: +row, -row, +col, -col
                case (nb_reg)
                    2'd0:
                    begin
                        q_push_data.r = ent_reg.r + 1'b1;
                        qctl.push     = ({1'b0, ent_reg.r} + 1'b1 < rows_reg);
                    end
                    2'd1:
                    begin
                        q_push_data.r = ent_reg.r - 1'b1;
                        qctl.push     = (ent_reg.r != '0);
                    end
                    2'd2:
                    begin
                        q_push_data.c = ent_reg.c + 1'b1;
                        qctl.push     = ({1'b0, ent_reg.c} + 1'b1 < cols_reg);
                    end
                    default:
                    begin
                        q_push_data.c = ent_reg.c - 1'b1;
                        qctl.push     = (ent_reg.c != '0);
                    end
                endcase
                if (qctl.push && qstat.full)
                    ovf_next = 1'b1;
                nb_next = nb_reg + 1'b1;
                if (nb_reg == 2'd3)
                    state_next = S_POP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            clr_seed_reg <= 1'b1;
            ovf_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            clr_seed_reg <= clr_seed_next;
            ovf_reg      <= ovf_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_r_reg   <= scan_r_next;
        scan_c_reg   <= scan_c_next;
        ent_reg      <= ent_next;
        acc_reg      <= acc_next;
        nb_reg       <= nb_next;
        infl_out_reg <= infl_out_next;
        bnd_out_reg  <= bnd_out_next;
    end

    // bitmap memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (seed_we)
            seed_mem[seed_wa] <= seed_wd;
        seed_q <= seed_mem[seed_ra];
    end

    always_ff @(posedge clk)
    begin
        if (infl_we)
            infl_mem[map_wa] <= infl_wd;
        infl_q <= infl_mem[map_ra];
    end

    always_ff @(posedge clk)
    begin
        if (bnd_we)
            bnd_mem[map_wa] <= bnd_wd;
        bnd_q <= bnd_mem[map_ra];
    end

endmodule

>>> rtl/oif_fill_queue.sv
// fifo of pending fill entries with head, tail and count
module oif_fill_queue
    import oif_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  qctl_t   ctl,
    input  qentry_t push_data,
    output qentry_t pop_data,
    output qstat_t  stat
);

    qentry_t mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push    = ctl.push && !stat.full;
    assign do_pop     = ctl.pop && !stat.empty;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else
        begin
            if (do_push)
                tail_next = tail_reg + 1'b1;
            if (do_pop)
                head_next = head_reg + 1'b1;
            if (do_push && !do_pop)
                count_next = count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push && !ctl.clear)
            mem[tail_reg] <= push_data;
        if (do_pop)
            pop_data <= mem[head_reg];
    end

endmodule

>>> dv/obstacle_inflation_fill_tb.sv
// self-checking testbench for the obstacle inflation fill block
module obstacle_inflation_fill_tb;
    import oif_pkg::*;

    // one result transaction: the two map bits and the sticky overflow flag
    typedef struct packed {
        logic inflated;
        logic boundary;
        logic overflow;
    } pix_result_t;

    // directed stimulus row; typed rows carry a hand-written answer
    typedef struct {
        logic [1:0]       cmd;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        logic             s;
        bit               typed;
        pix_result_t      answer;
    } directed_row_t;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         N_PIX      = MAX_ROWS * MAX_COLS;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        command;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              seed;
    logic              done;
    logic              inflated;
    logic              boundary;
    logic              overflow;
    logic              cfg_write;
    logic [1:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    obstacle_inflation_fill DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .row       (row),
        .col       (col),
        .seed      (seed),
        .done      (done),
        .inflated  (inflated),
        .boundary  (boundary),
        .overflow  (overflow),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block: maps, settings and the fill queue
    bit          seed_map     [N_PIX];
    bit          inflated_map [N_PIX];
    bit          boundary_map [N_PIX];
    bit          overflow_seen;
    int unsigned radius_sq;
    int unsigned area_rows;
    int unsigned area_cols;
    qentry_t     fill_q[$];

    // results still owed by the block, oldest first
    pix_result_t owed_results[$];

    int mismatches;
    int items_sent;
    int results_seen;
    int runs_sent;
    int reads_sent;
    int burst_left;

    function automatic int unsigned clamp_area(int unsigned v, int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    // push into the shadow fill queue; a full queue drops and flags
    function automatic void fill_push(int unsigned r, int unsigned c,
                                      int unsigned sr, int unsigned sc);
        qentry_t e;
        if (fill_q.size() >= QUEUE_DEPTH)
        begin
            overflow_seen = 1'b1;
            return;
        end
        e.r  = r[ROW_W-1:0];
        e.c  = c[COL_W-1:0];
        e.sr = sr[ROW_W-1:0];
        e.sc = sc[COL_W-1:0];
        fill_q.insert(fill_q.size(), e);
    endfunction

    // brushfire fill: seeds in raster order, then breadth-first drain
    function automatic void brushfire_run();
        qentry_t     e;
        int unsigned idx;
        int unsigned dx;
        int unsigned dy;
        for (int i = 0; i < N_PIX; i++)
        begin
            inflated_map[i] = 1'b0;
            boundary_map[i] = 1'b0;
        end
        fill_q.delete();
        overflow_seen = 1'b0;
        for (int unsigned r = 0; r < area_rows; r++)
            for (int unsigned c = 0; c < area_cols; c++)
                if (seed_map[r * MAX_COLS + c])
                    fill_push(r, c, r, c);
        while (fill_q.size() > 0)
        begin
            e   = fill_q.pop_front();
            idx = e.r * MAX_COLS + e.c;
            if (inflated_map[idx])
                continue;
            dx = (e.r >= e.sr) ? e.r - e.sr : e.sr - e.r;
            dy = (e.c >= e.sc) ? e.c - e.sc : e.sc - e.c;
            if (dx * dx + dy * dy > radius_sq)
            begin
                boundary_map[idx] = 1'b1;
                continue;
            end
            inflated_map[idx] = 1'b1;
            if (e.r + 1 < area_rows)
                fill_push(e.r + 1, e.c, e.sr, e.sc);
            if (e.r > 0)
                fill_push(e.r - 1, e.c, e.sr, e.sc);
            if (e.c + 1 < area_cols)
                fill_push(e.r, e.c + 1, e.sr, e.sc);
            if (e.c > 0)
                fill_push(e.r, e.c - 1, e.sr, e.sc);
        end
    endfunction

    // expected result of one accepted command, updating the shadow state
    function automatic pix_result_t predict_pixel(logic [1:0] cmd, logic [ROW_W-1:0] r,
                                                  logic [COL_W-1:0] c, logic s);
        pix_result_t res;
        int unsigned idx;
        idx = r * MAX_COLS + c;
        res = '0;
        case (cmd)
            CMD_WRITE: seed_map[idx] = s;
            CMD_RUN:   brushfire_run();
            CMD_READ:
            begin
                res.inflated = inflated_map[idx];
                res.boundary = boundary_map[idx];
            end
            default: ;
        endcase
        res.overflow = overflow_seen;
        return res;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #400_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result checker: done is registered, so sample it mid-cycle
    always @(negedge clk)
    begin
        pix_result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: inf=%0b bnd=%0b ovf=%0b",
                             inflated, boundary, overflow);
            end
            else
            begin
                want = owed_results.pop_front();
                if (inflated !== want.inflated || boundary !== want.boundary ||
                    overflow !== want.overflow)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp inf=%0b bnd=%0b ovf=%0b, got %0b %0b %0b",
                                 want.inflated, want.boundary, want.overflow,
                                 inflated, boundary, overflow);
                end
            end
        end
    end

    // one command transaction; the sender idles in bursts with random gaps
    task automatic send_cmd(logic [1:0] cmd, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                            logic s, bit typed, pix_result_t answer);
        pix_result_t pred;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            // some bursts run back to back with no gap at all
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        start   <= 1'b1;
        command <= cmd;
        row     <= r;
        col     <= c;
        seed    <= s;
        // busy only moves at rising edges, so the value at the falling edge
        // tells whether the next rising edge takes the transaction
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
        pred = predict_pixel(cmd, r, c, s);
        owed_results.insert(owed_results.size(), typed ? answer : pred);
        items_sent++;
        if (cmd == CMD_RUN)
            runs_sent++;
        if (cmd == CMD_READ)
            reads_sent++;
    endtask

    task automatic send_random(logic [1:0] cmd, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                               logic s);
        send_cmd(cmd, r, c, s, 1'b0, '0);
    endtask

    // stop sending and let every owed result arrive, plus a margin
    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_RADIUS: radius_sq = data;
            CFG_ROWS:   area_rows = clamp_area(data[AREA_W-1:0], MAX_ROWS);
            CFG_COLS:   area_cols = clamp_area(data[AREA_W-1:0], MAX_COLS);
            default: ;
        endcase
    endtask

    // pick an address: mostly inside the area in use, sometimes anywhere
    function automatic logic [ROW_W-1:0] pick_row();
        if ($urandom_range(0, 7) == 0)
            return ROW_W'($urandom_range(0, MAX_ROWS - 1));
        return ROW_W'($urandom_range(0, area_rows - 1));
    endfunction

    function automatic logic [COL_W-1:0] pick_col();
        if ($urandom_range(0, 7) == 0)
            return COL_W'($urandom_range(0, MAX_COLS - 1));
        return COL_W'($urandom_range(0, area_cols - 1));
    endfunction

    // directed stimulus at reset settings: radius squared 100, full 128 x 128
    directed_row_t directed[] = '{
        '{CMD_READ,   7'd0,   7'd0,   1'b0, 1'b1, 3'b000},  // maps empty after reset
        '{CMD_READ,   7'd127, 7'd127, 1'b0, 1'b1, 3'b000},
        '{CMD_UNUSED, 7'd5,   7'd5,   1'b1, 1'b1, 3'b000},  // unused command is a no-op
        '{CMD_WRITE,  7'd0,   7'd0,   1'b1, 1'b1, 3'b000},  // corner seeds
        '{CMD_WRITE,  7'd127, 7'd127, 1'b1, 1'b1, 3'b000},
        '{CMD_RUN,    7'd0,   7'd0,   1'b0, 1'b1, 3'b000},
        '{CMD_READ,   7'd0,   7'd0,   1'b0, 1'b1, 3'b100},  // the seed itself
        '{CMD_READ,   7'd10,  7'd0,   1'b0, 1'b1, 3'b100},  // exactly on the radius
        '{CMD_READ,   7'd11,  7'd0,   1'b0, 1'b1, 3'b010},  // one step past it
        '{CMD_READ,   7'd127, 7'd127, 1'b0, 1'b1, 3'b100},
        '{CMD_READ,   7'd6,   7'd8,   1'b0, 1'b0, 3'b000},
        '{CMD_READ,   7'd8,   7'd7,   1'b0, 1'b0, 3'b000},
        '{CMD_READ,   7'd64,  7'd64,  1'b0, 1'b1, 3'b000},  // far from both seeds
        '{CMD_UNUSED, 7'd0,   7'd0,   1'b0, 1'b1, 3'b000},
        '{CMD_WRITE,  7'd127, 7'd127, 1'b0, 1'b1, 3'b000},  // clear a seed again
        '{CMD_WRITE,  7'd60,  7'd3,   1'b1, 1'b1, 3'b000},
        '{CMD_RUN,    7'd0,   7'd0,   1'b0, 1'b1, 3'b000},  // rerun clears old marks
        '{CMD_READ,   7'd127, 7'd127, 1'b0, 1'b1, 3'b000},
        '{CMD_READ,   7'd60,  7'd13,  1'b0, 1'b1, 3'b100},
        '{CMD_READ,   7'd60,  7'd14,  1'b0, 1'b1, 3'b010},
        '{CMD_READ,   7'd55,  7'd0,   1'b0, 1'b0, 3'b000}
    };

    initial
    begin
        int kind;
        int n;
        rst_n      = 1'b0;
        start      = 1'b0;
        command    = CMD_WRITE;
        row        = '0;
        col        = '0;
        seed       = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_RADIUS;
        cfg_data   = '0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        runs_sent  = 0;
        reads_sent = 0;
        burst_left = 0;
        for (int i = 0; i < N_PIX; i++)
        begin
            seed_map[i]     = 1'b0;
            inflated_map[i] = 1'b0;
            boundary_map[i] = 1'b0;
        end
        overflow_seen = 1'b0;
        radius_sq     = 100;
        area_rows     = 128;
        area_cols     = 128;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part; the post-reset clearing pass shows up as busy
        foreach (directed[i])
            send_cmd(directed[i].cmd, directed[i].r, directed[i].c, directed[i].s,
                     directed[i].typed, directed[i].answer);
        drain();

        // clear leftover seeds so the random phases start from a clean map
        send_random(CMD_WRITE, 7'd0, 7'd0, 1'b0);
        send_random(CMD_WRITE, 7'd60, 7'd3, 1'b0);

        // random phases: settings, stray reads and commands, seed writes, a run, then reads
        while (items_sent < 1750)
        begin
            drain();
            kind = $urandom_range(0, 19);
            if (kind == 0)
            begin
                // full map with a modest radius
                write_reg(CFG_ROWS, 15'd128);
                write_reg(CFG_COLS, 15'd128);
                write_reg(CFG_RADIUS, CFG_W'($urandom_range(0, 40)));
            end
            else if (kind == 1)
            begin
                // out-of-range area settings and radius extremes on a thin strip
                if ($urandom_range(0, 1))
                begin
                    write_reg(CFG_ROWS, 15'd0);
                    write_reg(CFG_COLS, $urandom_range(0, 1) ? 15'd255 : 15'd200);
                end
                else
                begin
                    write_reg(CFG_ROWS, $urandom_range(0, 1) ? 15'd255 : 15'd129);
                    write_reg(CFG_COLS, 15'd0);
                end
                write_reg(CFG_RADIUS, $urandom_range(0, 1) ? 15'h7fff : 15'd0);
            end
            else
            begin
                write_reg(CFG_ROWS, CFG_W'($urandom_range(1, 20)));
                write_reg(CFG_COLS, CFG_W'($urandom_range(1, 20)));
                if ($urandom_range(0, 9) == 0)
                    write_reg(CFG_RADIUS, CFG_W'($urandom_range(0, 32767)));
                else
                    write_reg(CFG_RADIUS, CFG_W'($urandom_range(0, 60)));
            end

            // noise: reads of the previous maps and a stray unused command
            n = $urandom_range(0, 3);
            repeat (n)
                send_random(CMD_READ, pick_row(), pick_col(), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 4) == 0)
                send_random(CMD_UNUSED, ROW_W'($urandom_range(0, 127)),
                            COL_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));

            n = $urandom_range(2, 20);
            repeat (n)
                send_random(CMD_WRITE, pick_row(), pick_col(), $urandom_range(0, 2) == 0);
            send_random(CMD_RUN, ROW_W'($urandom_range(0, 127)),
                        COL_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));

            n = $urandom_range(10, 40);
            repeat (n)
                send_random(CMD_READ, pick_row(), pick_col(), 1'($urandom_range(0, 1)));

            // occasionally a second run over the same seeds
            if ($urandom_range(0, 5) == 0)
            begin
                send_random(CMD_RUN, 7'd0, 7'd0, 1'b0);
                repeat (10)
                    send_random(CMD_READ, pick_row(), pick_col(), 1'b0);
            end
        end

        // wait out the last results and any trailing activity
        drain();
        repeat (100) @(posedge clk);

        $display("covered %0d command transactions (%0d runs, %0d reads), %0d results checked",
                 items_sent, runs_sent, reads_sent, results_seen);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
